/* hw/rtl/brsr_pkg.sv */
// Package for the bidirectional random shift register unit.
// Holds the sequencer state type, switch codes, register indexes and sizing constants.
// No dependencies.
package brsr_pkg;

	// Ring and tap sizes.
	localparam int NUM_CELLS = 6;
	localparam int TAP_CELLS = 3;

	// Sample widths and derived tap sizes.
	localparam int SMP_W     = 12;
	localparam int TAP_W     = 2 * TAP_CELLS;
	localparam int TAP_SHIFT = SMP_W - TAP_W;
	localparam int LVL_W     = SMP_W + 2;
	localparam int GAIN_W    = SMP_W + 1;

	// Shared multiplier operand and product widths.
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 22;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Noise generator constants.
	localparam logic [31:0]        LCG_ADD = 32'd1013904223;
	localparam logic [MUL_B_W-1:0] LCG_MUL = 22'd1664525;

	// Threshold dead zone.
	localparam logic [SMP_W-1:0] P_DEAD_LO = 12'd15;
	localparam logic [SMP_W-1:0] P_DEAD_HI = 12'd4080;

	// Switch codes; the spare code behaves as the middle position.
	localparam logic [1:0] SW_MIDDLE = 2'd0;
	localparam logic [1:0] SW_UP     = 2'd1;
	localparam logic [1:0] SW_DOWN   = 2'd2;
	localparam logic [1:0] SW_SPARE  = 2'd3;

	// Configuration register index and jack mask bits.
	localparam logic REG_JACK_MASK = 1'b0;
	localparam int   JACK_AUDIO1   = 0;
	localparam int   JACK_AUDIO2   = 1;
	localparam int   JACK_CV1      = 2;
	localparam int   JACK_CV2      = 3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NOISE_F,
		ST_EDGE_F,
		ST_NOISE_B,
		ST_EDGE_B,
		ST_OFS_MUL,
		ST_GAIN_MUL,
		ST_GAIN_SET,
		ST_LVL1_MUL,
		ST_LVL2_MUL,
		ST_FINISH
	} brsr_state_t;

endpackage

/* hw/rtl/bidirectional_random_shift_register_unit.sv */
// Top level of the bidirectional random shift register unit.
// Ring of cells, with the noise generator, sample and hold, and level taps sharing one multiplier.
// Depends on brsr_pkg.
//
// Steps: a tick with no clock edge runs the two level products and the finish step; an edge
// first adds its noise and edge steps (forward first when both), then the offset, gain and
// gain-set steps. All products come from the single shared multiplier. The input is taken only
// in the idle step, so one item ends before the next is taken, which may be while the result waits.
// Reset (arst_n low, asynchronous): cells 0, noise seed 1, held offset and gain 0, mask 0.
module bidirectional_random_shift_register_unit
	import brsr_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// Configuration port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [2:0]               paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	// Input channel
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     fwd_edge,
	input  logic                     back_edge,
	input  logic [1:0]               switch_pos,
	input  logic [SMP_W-1:0]         main_knob,
	input  logic [SMP_W-1:0]         knob_x,
	input  logic [SMP_W-1:0]         knob_y,
	input  logic signed [SMP_W-1:0]  audio_in1,
	input  logic signed [SMP_W-1:0]  audio_in2,
	input  logic signed [SMP_W-1:0]  cv_in1,
	input  logic signed [SMP_W-1:0]  cv_in2,
	// Output channel
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [SMP_W-1:0]  audio_out1,
	output logic signed [SMP_W-1:0]  audio_out2,
	output logic signed [SMP_W-1:0]  level_out1,
	output logic signed [SMP_W-1:0]  level_out2,
	output logic                     pulse_out1,
	output logic                     pulse_out2,
	output logic [11:0]              cell_contents
);

	brsr_state_t state_q, state_d;

	// Configuration
	logic [3:0] jack_mask_q;
	logic       cfg_wr;

	// Captured item
	logic                    be_q;
	logic [1:0]              sw_q;
	logic [SMP_W-1:0]        mk_q, kx_q, ky_q;
	logic signed [SMP_W-1:0] a1_q, a2_q, c1_q, c2_q;

	// Block state
	logic [1:0]        cells_q [NUM_CELLS];
	logic [31:0]       seed_q;
	logic [SMP_W-1:0]  offset_q;
	logic [GAIN_W-1:0] gain_q;
	logic signed [LVL_W-1:0] lvl1_q;

	// Shared multiplier
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;
	logic signed [MUL_P_W-1:0] prod_q;

	// Output register
	logic                    out_valid_q;
	logic signed [SMP_W-1:0] audio1_q, audio2_q, level1_q, level2_q;
	logic                    pulse1_q, pulse2_q;
	logic [11:0]             contents_q;
	logic                    out_load;

	// Threshold and derived control
	logic signed [LVL_W-1:0] p_sum;
	logic [SMP_W-1:0]        p_clip;
	logic [SMP_W-1:0]        p_thr;
	logic                    stable;
	logic                    rand_mode;
	logic                    use_noise;
	logic [31:0]             seed_new;
	logic [SMP_W-1:0]        data_smp;

	// Hold and level helpers
	logic signed [SMP_W:0]   kx_ofs;
	logic signed [GAIN_W-1:0] gain_raw;
	logic [SMP_W-1:0]        gain_clamp;
	logic [TAP_W-1:0]        tap1, tap2;
	logic [SMP_W-1:0]        tap1_scaled, tap2_scaled;
	logic signed [LVL_W-1:0] lvl_now;
	logic [11:0]             packed_cells;

	function automatic logic signed [SMP_W-1:0] clip_level(input logic signed [LVL_W-1:0] v);
		logic signed [LVL_W-1:0] lo, hi;
		lo = -(LVL_W'(2048));
		hi = LVL_W'(2047);
		if (v < lo)
			return SMP_W'(lo);
		else if (v > hi)
			return SMP_W'(hi);
		else
			return v[SMP_W-1:0];
	endfunction

	// Rewrite of the cell that enters at the open end of the ring.
	function automatic logic [1:0] rewrite_cell(
		input logic [1:0]       cur,
		input logic             fwd,
		input logic [1:0]       sw,
		input logic             stbl,
		input logic [SMP_W-1:0] p,
		input logic [SMP_W-1:0] data
	);
		logic [SMP_W-1:0] d;
		d = data;
		if (sw == SW_DOWN)
			return fwd ? 2'b11 : 2'b00;
		else if (sw == SW_UP || stbl)
			return ~cur;
		else begin
			if (!fwd) begin
				if (d == '0)
					d = SMP_W'(1);
				else if (d == '1)
					d = SMP_W'(4094);
			end
			return (d > p) ? ~d[1:0] : cur;
		end
	endfunction

	// APB register access
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_JACK_MASK) ? {28'd0, jack_mask_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jack_mask_q <= '0;
		end else if (cfg_wr && paddr[2] == REG_JACK_MASK) begin
			jack_mask_q <= pwdata[3:0];
		end
	end

	// Probability threshold with its dead zones.
	always_comb begin
		if (jack_mask_q[JACK_AUDIO2])
			p_sum = LVL_W'(a2_q) + $signed({2'b00, mk_q});
		else
			p_sum = $signed({2'b00, mk_q});
		if (p_sum[LVL_W-1])
			p_clip = '0;
		else if (p_sum > $signed(LVL_W'(4095)))
			p_clip = '1;
		else
			p_clip = p_sum[SMP_W-1:0];
		stable = p_clip < P_DEAD_LO;
		if (stable)
			p_thr = '0;
		else if (p_clip > P_DEAD_HI)
			p_thr = '1;
		else
			p_thr = p_clip;
	end

	assign rand_mode = (sw_q != SW_DOWN) && (sw_q != SW_UP) && !stable;
	assign use_noise = rand_mode && !jack_mask_q[JACK_AUDIO1];
	assign seed_new  = prod_q[31:0] + LCG_ADD;
	// Audio sample plus 2048 is the sample with its sign bit flipped.
	assign data_smp  = jack_mask_q[JACK_AUDIO1] ? {~a1_q[SMP_W-1], a1_q[SMP_W-2:0]}
	                                             : seed_new[31:20];

	// Taps and packed cells
	always_comb begin
		for (int i = 0; i < TAP_CELLS; i++) begin
			tap1[2*i +: 2] = cells_q[i];
			tap2[2*i +: 2] = cells_q[NUM_CELLS-TAP_CELLS+i];
		end
		for (int i = 0; i < 6; i++)
			packed_cells[2*i +: 2] = cells_q[i];
	end
	assign tap1_scaled = SMP_W'(tap1) << TAP_SHIFT;
	assign tap2_scaled = SMP_W'(tap2) << TAP_SHIFT;

	assign kx_ofs   = $signed({1'b0, kx_q}) - $signed((SMP_W+1)'(2048));
	assign gain_raw = prod_q[SMP_W+12:12];
	always_comb begin
		if (gain_raw[GAIN_W-1])
			gain_clamp = '0;
		else if (gain_raw > $signed(GAIN_W'(2048)))
			gain_clamp = SMP_W'(2048);
		else
			gain_clamp = gain_raw[SMP_W-1:0];
	end

	// Product scaled down by 4096, plus offset, recentred.
	assign lvl_now = $signed({2'b00, prod_q[SMP_W+11:12]}) + $signed({2'b00, offset_q})
	                 - $signed(LVL_W'(2048));

	assign out_load = !out_valid_q || out_ready;

	// Sequencer: next state and multiplier operands.
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (fwd_edge)
						state_d = ST_NOISE_F;
					else if (back_edge)
						state_d = ST_NOISE_B;
					else
						state_d = ST_LVL1_MUL;
				end
			end
			ST_NOISE_F: begin
				mul_a   = $signed({1'b0, seed_q});
				mul_b   = $signed(LCG_MUL);
				state_d = ST_EDGE_F;
			end
			ST_EDGE_F: begin
				state_d = be_q ? ST_NOISE_B : ST_OFS_MUL;
			end
			ST_NOISE_B: begin
				mul_a   = $signed({1'b0, seed_q});
				mul_b   = $signed(LCG_MUL);
				state_d = ST_EDGE_B;
			end
			ST_EDGE_B: begin
				state_d = ST_OFS_MUL;
			end
			ST_OFS_MUL: begin
				mul_a   = MUL_A_W'(c1_q);
				mul_b   = MUL_B_W'(kx_ofs);
				state_d = ST_GAIN_MUL;
			end
			ST_GAIN_MUL: begin
				mul_a   = MUL_A_W'(c2_q);
				mul_b   = $signed({{(MUL_B_W-SMP_W){1'b0}}, ky_q});
				state_d = ST_GAIN_SET;
			end
			ST_GAIN_SET: begin
				state_d = ST_LVL1_MUL;
			end
			ST_LVL1_MUL: begin
				mul_a   = $signed({{(MUL_A_W-SMP_W){1'b0}}, tap1_scaled});
				mul_b   = $signed({{(MUL_B_W-GAIN_W){1'b0}}, gain_q});
				state_d = ST_LVL2_MUL;
			end
			ST_LVL2_MUL: begin
				mul_a   = $signed({{(MUL_A_W-SMP_W){1'b0}}, tap2_scaled});
				mul_b   = $signed({{(MUL_B_W-GAIN_W){1'b0}}, gain_q});
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_load)
					state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		// The second level product is held while the result waits for the output register.
		if (state_q != ST_FINISH)
			prod_q <= mul_p;
		if (state_q == ST_IDLE && in_valid) begin
			be_q <= back_edge;
			sw_q <= switch_pos;
			mk_q <= main_knob;
			kx_q <= knob_x;
			ky_q <= knob_y;
			a1_q <= audio_in1;
			a2_q <= audio_in2;
			c1_q <= cv_in1;
			c2_q <= cv_in2;
		end
		if (state_q == ST_LVL2_MUL)
			lvl1_q <= lvl_now;
	end

	// Ring, noise seed and held values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CELLS; i++)
				cells_q[i] <= '0;
			seed_q   <= 32'd1;
			offset_q <= '0;
			gain_q   <= '0;
		end else begin
			case (state_q)
				ST_EDGE_F: begin
					for (int i = 1; i < NUM_CELLS; i++)
						cells_q[i] <= cells_q[i-1];
					cells_q[0] <= rewrite_cell(cells_q[NUM_CELLS-1], 1'b1, sw_q, stable,
					                           p_thr, data_smp);
					if (use_noise)
						seed_q <= seed_new;
				end
				ST_EDGE_B: begin
					for (int i = 0; i < NUM_CELLS - 1; i++)
						cells_q[i] <= cells_q[i+1];
					cells_q[NUM_CELLS-1] <= rewrite_cell(cells_q[0], 1'b0, sw_q, stable,
					                                     p_thr, data_smp);
					if (use_noise)
						seed_q <= seed_new;
				end
				ST_GAIN_MUL: begin
					// Offset product divided by 4096, recentred by flipping the top bit.
					if (jack_mask_q[JACK_CV1])
						offset_q <= {~prod_q[23], prod_q[22:12]};
					else
						offset_q <= kx_q;
				end
				ST_GAIN_SET: begin
					if (jack_mask_q[JACK_CV2])
						gain_q <= {gain_clamp, 1'b0};
					else
						gain_q <= {1'b0, ky_q};
				end
				default: begin
				end
			endcase
		end
	end

	// Output register; it is loaded as the sequencer leaves its last step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_load) begin
			audio1_q   <= clip_level(-lvl1_q);
			audio2_q   <= clip_level(-lvl_now);
			level1_q   <= clip_level(lvl1_q);
			level2_q   <= clip_level(lvl_now);
			pulse1_q   <= cells_q[TAP_CELLS-1][0];
			pulse2_q   <= cells_q[NUM_CELLS-1][0];
			contents_q <= packed_cells;
		end
	end

	assign out_valid     = out_valid_q;
	assign audio_out1    = audio1_q;
	assign audio_out2    = audio2_q;
	assign level_out1    = level1_q;
	assign level_out2    = level2_q;
	assign pulse_out1    = pulse1_q;
	assign pulse_out2    = pulse2_q;
	assign cell_contents = contents_q;

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for bidirectional_random_shift_register_unit.
// Predicts every result from its own model of the cell ring, noise generator and taps.
// Depends on brsr_pkg and the unit's RTL only.
module tb
	import brsr_pkg::*;
;

	typedef struct {
		logic              fwd_edge;
		logic              back_edge;
		logic [1:0]        switch_pos;
		logic [11:0]       main_knob;
		logic [11:0]       knob_x;
		logic [11:0]       knob_y;
		logic signed [11:0] audio_in1;
		logic signed [11:0] audio_in2;
		logic signed [11:0] cv_in1;
		logic signed [11:0] cv_in2;
	} knob_tick_t;

	typedef struct {
		logic signed [11:0] audio_out1;
		logic signed [11:0] audio_out2;
		logic signed [11:0] level_out1;
		logic signed [11:0] level_out2;
		logic               pulse_out1;
		logic               pulse_out2;
		logic [11:0]        cell_contents;
	} tap_levels_t;

	typedef enum int {
		PACE_FREE,
		PACE_SENDER_IDLE,
		PACE_RECEIVER_STALL,
		PACE_BOTH
	} pace_t;

	localparam logic [2:0] MASK_ADDR  = 3'(4 * REG_JACK_MASK);
	localparam logic [2:0] SPARE_ADDR = 3'd4;
	localparam int         PHASES     = 8;
	localparam int         PHASE_TICKS = 225;
	localparam logic [3:0] PHASE_MASKS [PHASES] = '{4'h0, 4'hF, 4'h1, 4'h2,
		4'h4, 4'h8, 4'h5, 4'hA};

	// Ring model and store of the levels still owed by the unit.
	class ring_tap_checker_t;
		logic [1:0]  ring [NUM_CELLS];
		logic [31:0] lcg;
		logic [11:0] offset_hold;
		logic [12:0] gain_hold;
		logic [3:0]  jacks;
		tap_levels_t due_levels [$];
		int          faults;

		function new();
			foreach (ring[i]) ring[i] = 2'd0;
			lcg = 32'd1;
			offset_hold = '0;
			gain_hold = '0;
			jacks = '0;
			faults = 0;
		endfunction

		function int clip(int v, int lo, int hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function int pending();
			return due_levels.size();
		endfunction

		function void step_ring(bit fwd, logic [1:0] sw, bit stable, int p, int a1);
			int         slot;
			int         d;
			logic [1:0] spill;
			slot = fwd ? 0 : NUM_CELLS - 1;
			if (fwd) begin
				spill = ring[NUM_CELLS-1];
				for (int i = NUM_CELLS - 1; i > 0; i--) ring[i] = ring[i-1];
				ring[0] = spill;
			end else begin
				spill = ring[0];
				for (int i = 0; i < NUM_CELLS - 1; i++) ring[i] = ring[i+1];
				ring[NUM_CELLS-1] = spill;
			end
			// The unused switch code falls through to the random branch.
			if (sw == SW_DOWN) begin
				ring[slot] = fwd ? 2'b11 : 2'b00;
			end else if (sw == SW_UP || stable) begin
				ring[slot] = ~ring[slot];
			end else begin
				if (jacks[JACK_AUDIO1]) begin
					d = a1 + 2048;
				end else begin
					lcg = lcg * 32'(LCG_MUL) + LCG_ADD;
					d = int'(lcg[31:20]);
				end
				if (!fwd) d = clip(d, 1, 4094);
				if (d > p) ring[slot] = ~d[1:0];
			end
		endfunction

		function void resample(int kx, int ky, int c1, int c2);
			int v;
			if (jacks[JACK_CV1]) begin
				v = ((c1 * (kx - 2048)) >>> 12) + 2048;
				offset_hold = v[11:0];
			end else begin
				offset_hold = kx[11:0];
			end
			if (jacks[JACK_CV2]) begin
				v = 2 * clip((c2 * ky) >>> 12, 0, 2048);
				gain_hold = v[12:0];
			end else begin
				gain_hold = ky[12:0];
			end
		endfunction

		function int level_at(int start);
			int tap;
			tap = 0;
			for (int i = 0; i < TAP_CELLS; i++) tap |= int'(ring[start+i]) << (2 * i);
			tap = tap << TAP_SHIFT;
			return ((tap * int'(gain_hold)) >>> 12) + int'(offset_hold) - 2048;
		endfunction

		function void note_tick(knob_tick_t t);
			int          p;
			bit          stable;
			int          l1;
			int          l2;
			tap_levels_t r;
			p = int'(t.main_knob);
			if (jacks[JACK_AUDIO2]) p += int'(t.audio_in2);
			p = clip(p, 0, 4095);
			stable = 1'b0;
			if (p < 15) begin
				p = 0;
				stable = 1'b1;
			end else if (p > 4095 - 15) begin
				p = 4095;
			end
			if (t.fwd_edge) begin
				step_ring(1'b1, t.switch_pos, stable, p, int'(t.audio_in1));
				resample(int'(t.knob_x), int'(t.knob_y), int'(t.cv_in1), int'(t.cv_in2));
			end
			if (t.back_edge) begin
				step_ring(1'b0, t.switch_pos, stable, p, int'(t.audio_in1));
				resample(int'(t.knob_x), int'(t.knob_y), int'(t.cv_in1), int'(t.cv_in2));
			end
			l1 = level_at(0);
			l2 = level_at(NUM_CELLS - TAP_CELLS);
			r.audio_out1 = 12'(clip(-l1, -2048, 2047));
			r.audio_out2 = 12'(clip(-l2, -2048, 2047));
			r.level_out1 = 12'(clip(l1, -2048, 2047));
			r.level_out2 = 12'(clip(l2, -2048, 2047));
			r.pulse_out1 = ring[TAP_CELLS-1][0];
			r.pulse_out2 = ring[NUM_CELLS-1][0];
			r.cell_contents = '0;
			for (int i = 0; i < NUM_CELLS && i < 6; i++) r.cell_contents[2*i +: 2] = ring[i];
			due_levels.push_back(r);
		endfunction

		function void compare_field(string name, logic signed [31:0] want,
				logic signed [31:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
				faults++;
			end
		endfunction

		function void check_levels(tap_levels_t got);
			tap_levels_t want;
			if (due_levels.size() == 0) begin
				$display("%0t: result with no item outstanding, cells %h", $time,
					got.cell_contents);
				faults++;
				return;
			end
			want = due_levels.pop_front();
			compare_field("audio_out1", 32'(want.audio_out1), 32'(got.audio_out1));
			compare_field("audio_out2", 32'(want.audio_out2), 32'(got.audio_out2));
			compare_field("level_out1", 32'(want.level_out1), 32'(got.level_out1));
			compare_field("level_out2", 32'(want.level_out2), 32'(got.level_out2));
			compare_field("pulse_out1", {31'd0, want.pulse_out1}, {31'd0, got.pulse_out1});
			compare_field("pulse_out2", {31'd0, want.pulse_out2}, {31'd0, got.pulse_out2});
			compare_field("cell_contents", {20'd0, want.cell_contents},
				{20'd0, got.cell_contents});
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [2:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               fwd_edge = 1'b0;
	logic               back_edge = 1'b0;
	logic [1:0]         switch_pos = '0;
	logic [11:0]        main_knob = '0;
	logic [11:0]        knob_x = '0;
	logic [11:0]        knob_y = '0;
	logic signed [11:0] audio_in1 = '0;
	logic signed [11:0] audio_in2 = '0;
	logic signed [11:0] cv_in1 = '0;
	logic signed [11:0] cv_in2 = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [11:0] audio_out1;
	logic signed [11:0] audio_out2;
	logic signed [11:0] level_out1;
	logic signed [11:0] level_out2;
	logic               pulse_out1;
	logic               pulse_out2;
	logic [11:0]        cell_contents;

	ring_tap_checker_t ring_check;
	tap_levels_t       seen_levels;
	int                idle_pct = 0;
	int                stall_pct = 0;

	bidirectional_random_shift_register_unit uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.fwd_edge(fwd_edge), .back_edge(back_edge), .switch_pos(switch_pos),
		.main_knob(main_knob), .knob_x(knob_x), .knob_y(knob_y),
		.audio_in1(audio_in1), .audio_in2(audio_in2), .cv_in1(cv_in1), .cv_in2(cv_in2),
		.out_valid(out_valid), .out_ready(out_ready),
		.audio_out1(audio_out1), .audio_out2(audio_out2),
		.level_out1(level_out1), .level_out2(level_out2),
		.pulse_out1(pulse_out1), .pulse_out2(pulse_out2),
		.cell_contents(cell_contents)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always_comb begin
		seen_levels.audio_out1 = audio_out1;
		seen_levels.audio_out2 = audio_out2;
		seen_levels.level_out1 = level_out1;
		seen_levels.level_out2 = level_out2;
		seen_levels.pulse_out1 = pulse_out1;
		seen_levels.pulse_out2 = pulse_out2;
		seen_levels.cell_contents = cell_contents;
	end

	// Values read here are those from just before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) ring_check.check_levels(seen_levels);
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	task automatic set_pace(input pace_t pace);
		case (pace)
			PACE_FREE: begin
				idle_pct = 0;
				stall_pct = 0;
			end
			PACE_SENDER_IDLE: begin
				idle_pct = 65;
				stall_pct = 0;
			end
			PACE_RECEIVER_STALL: begin
				idle_pct = 0;
				stall_pct = 65;
			end
			default: begin
				idle_pct = 19;
				stall_pct = 19;
			end
		endcase
	endtask

	// Called at a rising edge; returns at the edge where the item is taken.
	task automatic send_tick(input knob_tick_t t);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		fwd_edge   <= t.fwd_edge;
		back_edge  <= t.back_edge;
		switch_pos <= t.switch_pos;
		main_knob  <= t.main_knob;
		knob_x     <= t.knob_x;
		knob_y     <= t.knob_y;
		audio_in1  <= t.audio_in1;
		audio_in2  <= t.audio_in2;
		cv_in1     <= t.cv_in1;
		cv_in2     <= t.cv_in2;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		ring_check.note_tick(t);
	endtask

	// Lets every owed result drain, then gives the unit time to go idle.
	task automatic settle();
		in_valid <= 1'b0;
		while (ring_check.pending() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (addr == MASK_ADDR) ring_check.jacks = value[3:0];
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	function automatic knob_tick_t make_tick(bit fe, bit be, logic [1:0] sw, int mk,
			int kx, int ky, int a1, int a2, int c1, int c2);
		knob_tick_t t;
		t.fwd_edge = fe;
		t.back_edge = be;
		t.switch_pos = sw;
		t.main_knob = mk[11:0];
		t.knob_x = kx[11:0];
		t.knob_y = ky[11:0];
		t.audio_in1 = a1[11:0];
		t.audio_in2 = a2[11:0];
		t.cv_in1 = c1[11:0];
		t.cv_in2 = c2[11:0];
		return t;
	endfunction

	// Edges are frequent and the probability knob often sits in or near a dead zone.
	function automatic knob_tick_t random_tick();
		knob_tick_t t;
		t.fwd_edge = ($urandom_range(0, 99) < 70);
		t.back_edge = ($urandom_range(0, 99) < 55);
		t.switch_pos = ($urandom_range(0, 1) != 0) ? SW_MIDDLE : 2'($urandom_range(0, 3));
		case ($urandom_range(0, 3))
			0: t.main_knob = 12'($urandom_range(0, 30));
			1: t.main_knob = 12'($urandom_range(4065, 4095));
			default: t.main_knob = 12'($urandom_range(0, 4095));
		endcase
		t.knob_x = 12'($urandom_range(0, 4095));
		t.knob_y = 12'($urandom_range(0, 4095));
		t.audio_in1 = 12'($urandom_range(0, 4095));
		t.audio_in2 = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 40) - 20)
			: 12'($urandom_range(0, 4095));
		t.cv_in1 = 12'($urandom_range(0, 4095));
		t.cv_in2 = 12'($urandom_range(0, 4095));
		return t;
	endfunction

	initial begin
		ring_check = new();
		set_pace(PACE_FREE);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With no jack patched: fixed writes, toggles, dead zones and the noise source.
		send_tick(make_tick(0, 0, SW_MIDDLE, 0, 0, 0, 0, 0, 0, 0));
		send_tick(make_tick(1, 0, SW_DOWN, 4095, 4095, 4095, 2047, 2047, 2047, 2047));
		send_tick(make_tick(0, 1, SW_DOWN, 4095, 2048, 4095, -2048, -2048, -2048, -2048));
		send_tick(make_tick(1, 0, SW_UP, 2000, 1000, 3000, 0, 0, 0, 0));
		send_tick(make_tick(0, 1, SW_UP, 2000, 3000, 1000, 0, 0, 0, 0));
		send_tick(make_tick(1, 0, SW_MIDDLE, 0, 2048, 2048, 0, 0, 0, 0));
		send_tick(make_tick(1, 0, SW_SPARE, 14, 2048, 4095, 0, 0, 0, 0));
		send_tick(make_tick(1, 0, SW_MIDDLE, 15, 100, 4095, 0, 0, 0, 0));
		send_tick(make_tick(1, 1, SW_MIDDLE, 4081, 2048, 4095, 0, 0, 0, 0));
		send_tick(make_tick(1, 1, SW_MIDDLE, 2000, 2048, 4095, 0, 0, 0, 0));
		send_tick(make_tick(1, 0, SW_MIDDLE, 4095, 0, 4095, 0, 0, 0, 0));
		send_tick(make_tick(0, 1, SW_SPARE, 100, 4095, 0, 0, 0, 0, 0));
		settle();

		// All jacks patched: audio data with its back-edge clip, probability sum, CV scaling.
		write_reg(SPARE_ADDR, 32'hFFFF_FFFF);
		write_reg(MASK_ADDR, 32'h0000_000F);
		send_tick(make_tick(1, 0, SW_MIDDLE, 2000, 2048, 4095, 2047, 0, 0, 2047));
		send_tick(make_tick(0, 1, SW_MIDDLE, 2000, 2048, 4095, 2047, 0, 0, 2047));
		send_tick(make_tick(0, 1, SW_MIDDLE, 2000, 2048, 4095, -2048, 0, 0, 2047));
		send_tick(make_tick(1, 0, SW_MIDDLE, 4095, 0, 4095, 0, 2047, -2048, 2047));
		send_tick(make_tick(1, 0, SW_MIDDLE, 0, 4095, 4095, 0, -2048, 2047, 2047));
		send_tick(make_tick(1, 0, SW_MIDDLE, 10, 2048, 2048, 1000, 5, 0, 2047));
		send_tick(make_tick(1, 0, SW_MIDDLE, 3000, 0, 4095, -1000, 0, -2048, -2048));
		send_tick(make_tick(0, 1, SW_MIDDLE, 3000, 4095, 4095, 500, 0, 2047, 2047));
		send_tick(make_tick(1, 1, SW_MIDDLE, 1000, 4095, 1, 1500, 0, -2048, 1000));
		send_tick(make_tick(0, 0, SW_DOWN, 1000, 4095, 4095, 0, 0, 2047, 2047));

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			write_reg(MASK_ADDR, {28'($urandom), PHASE_MASKS[ph]});
			set_pace(pace_t'(ph % 4));
			repeat (PHASE_TICKS) send_tick(random_tick());
		end
		settle();

		if (ring_check.faults == 0 && ring_check.pending() == 0) begin
			$display("bidirectional_random_shift_register_unit: match");
		end else begin
			$display("bidirectional_random_shift_register_unit: mismatch");
		end
		$finish;
	end

	initial begin
		#8000000;
		$display("bidirectional_random_shift_register_unit: mismatch");
		$finish;
	end

endmodule
